// File: hw/rtl/timer_and_interrupt_dispatch_assert.svh
// Assertion helpers; every user has clk_i and rst_ni in scope.
`ifndef TIMER_AND_INTERRUPT_DISPATCH_ASSERT_SVH
`define TIMER_AND_INTERRUPT_DISPATCH_ASSERT_SVH

// Same-cycle implication.
`define TIAD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TIAD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/tiad_pkg.sv
package tiad_pkg;

  typedef enum logic [2:0] {
    CmdTick      = 3'd0,
    CmdWrite     = 3'd1,
    CmdRead      = 3'd2,
    CmdDispatch  = 3'd3,
    CmdSetMaster = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    SelDivider = 3'd0,
    SelCounter = 3'd1,
    SelModulo  = 3'd2,
    SelControl = 3'd3,
    SelRequest = 3'd4,
    SelEnable  = 3'd5
  } sel_e;

  localparam int unsigned NumLines    = 5;
  localparam int unsigned LineW       = 3;
  localparam int unsigned TimerEnBit  = 2;
  localparam int unsigned TimerLine   = 2;
  localparam int unsigned PeriodW     = 11;
  localparam logic [10:0] PeriodReset = 11'd1024;
  localparam logic [10:0] TimerAccMax = 11'h7FF;
  localparam logic [6:0]  VecBase     = 7'h40;
  localparam int unsigned TdataW      = 24;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] write_data;
    logic [2:0] reg_select;
    logic [7:0] cycles;
  } item_t;

  // read_data sits in the low bits
  typedef struct packed {
    logic       timer_overflow;
    logic [6:0] irq_vector;
    logic [2:0] irq_line;
    logic       irq_taken;
    logic [7:0] read_data;
  } result_t;

endpackage

// File: hw/rtl/timer_and_interrupt_dispatch.sv
// Channel   Direction  Payload
// s_axis    in         tuser[2:0] command; tdata cycles, reg_select, write_data
// m_axis    out        tdata read_data, irq_taken, irq_line, irq_vector, timer_overflow
// cfg       in         cfg_data_i[10:0] timer_period, always ready
//
// One request per cycle sustained while m_axis_tready is high; a request passes
// through the input register, then execute into the result register.
// Reset: valid flags and state registers zero, master enable set, timer_period 1024.
// A stalled m_axis holds the result register; the input register still takes
// one more request before s_axis_tready drops, so neither side idles early.
// Tick, register and dispatch logic is one combinational pass over the state.
module timer_and_interrupt_dispatch #(
  parameter int unsigned DIV_PERIOD = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] cycles, [10:8] reg_select, [18:11] write_data, rest zero
  input  logic [tiad_pkg::TdataW-1:0]   s_axis_tdata,
  // [2:0] command
  input  logic [2:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] read_data, [8] irq_taken, [11:9] irq_line, [18:12] irq_vector,
  // [19] timer_overflow, rest zero
  output logic [tiad_pkg::TdataW-1:0]   m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tiad_pkg::PeriodW-1:0]  cfg_data_i
);

  localparam int unsigned ResW = $bits(tiad_pkg::result_t);

  tiad_pkg::item_t   item_q;
  logic              item_vld_q, item_vld_d;
  tiad_pkg::result_t res_q, res;
  logic              res_vld_q, res_vld_d;
  logic              advance;
  logic              in_hs;

  // execute when the result register is free or being drained
  assign advance       = item_vld_q && (!res_vld_q || m_axis_tready);
  assign s_axis_tready = !item_vld_q || advance;
  assign in_hs         = s_axis_tvalid && s_axis_tready;

  assign item_vld_d = s_axis_tready ? s_axis_tvalid : item_vld_q;
  assign res_vld_d  = advance ? 1'b1 : (m_axis_tready ? 1'b0 : res_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_hs) begin
      item_q.command    <= s_axis_tuser;
      item_q.cycles     <= s_axis_tdata[7:0];
      item_q.reg_select <= s_axis_tdata[10:8];
      item_q.write_data <= s_axis_tdata[18:11];
    end
    if (advance) begin
      res_q <= res;
    end
  end

  tiad_core #(
    .DIV_PERIOD (DIV_PERIOD)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .exec_i     (advance),
    .item_i     (item_q),
    .res_o      (res)
  );

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = res_vld_q;
  assign m_axis_tdata  = {(tiad_pkg::TdataW - ResW)'(0), res_q};

endmodule

// File: hw/rtl/tiad_prio.sv
// Lowest-index pending line wins.
module tiad_prio (
  input  logic [tiad_pkg::NumLines-1:0] pend_i,
  output logic                          found_o,
  output logic [tiad_pkg::LineW-1:0]    line_o
);

  always_comb begin
    found_o = 1'b0;
    line_o  = '0;
    for (int i = tiad_pkg::NumLines - 1; i >= 0; i--) begin
      if (pend_i[i]) begin
        found_o = 1'b1;
        line_o  = tiad_pkg::LineW'(i);
      end
    end
  end

endmodule

// File: hw/rtl/tiad_core.sv
// Architectural state and combinational execution of one request.
module tiad_core #(
  parameter int unsigned DIV_PERIOD = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tiad_pkg::PeriodW-1:0]   cfg_data_i,
  input  logic                           exec_i,
  input  tiad_pkg::item_t                item_i,
  output tiad_pkg::result_t              res_o
);

  localparam int unsigned DivAccW = $clog2(DIV_PERIOD);
  localparam int unsigned DivSumW = $clog2(DIV_PERIOD + 256);

  logic [tiad_pkg::PeriodW-1:0] period_q;
  logic [7:0]                   div_cnt_q, div_cnt_d;
  logic [DivAccW-1:0]           div_acc_q, div_acc_d;
  logic [tiad_pkg::PeriodW-1:0] tim_acc_q, tim_acc_d;
  logic [7:0]                   counter_q, counter_d;
  logic [7:0]                   modulo_q, modulo_d;
  logic [7:0]                   control_q, control_d;
  logic [7:0]                   request_q, request_d;
  logic [7:0]                   enable_q, enable_d;
  logic                         master_q, master_d;

  logic [DivSumW-1:0]             div_sum;
  logic [tiad_pkg::PeriodW:0]     tim_sum;
  logic [tiad_pkg::PeriodW-1:0]   tim_sat;
  logic                           pend_found;
  logic [tiad_pkg::LineW-1:0]     pend_line;
  logic [tiad_pkg::NumLines-1:0]  pend;
  tiad_pkg::result_t              res;

  assign pend = request_q[tiad_pkg::NumLines-1:0] & enable_q[tiad_pkg::NumLines-1:0];

  tiad_prio u_prio (
    .pend_i  (pend),
    .found_o (pend_found),
    .line_o  (pend_line)
  );

  assign div_sum = DivSumW'(div_acc_q) + DivSumW'(item_i.cycles);
  assign tim_sum = {1'b0, tim_acc_q} + (tiad_pkg::PeriodW + 1)'(item_i.cycles);
  assign tim_sat = tim_sum[tiad_pkg::PeriodW] ? tiad_pkg::TimerAccMax
                                              : tim_sum[tiad_pkg::PeriodW-1:0];

  always_comb begin
    div_cnt_d = div_cnt_q;
    div_acc_d = div_acc_q;
    tim_acc_d = tim_acc_q;
    counter_d = counter_q;
    modulo_d  = modulo_q;
    control_d = control_q;
    request_d = request_q;
    enable_d  = enable_q;
    master_d  = master_q;
    res       = '0;

    case (tiad_pkg::cmd_e'(item_i.command))
      tiad_pkg::CmdTick: begin
        if (control_q[tiad_pkg::TimerEnBit]) begin
          if (tim_sat >= period_q) begin
            tim_acc_d = '0;
            if (counter_q == 8'hFF) begin
              counter_d                     = modulo_q;
              request_d[tiad_pkg::TimerLine] = 1'b1;
              res.timer_overflow            = 1'b1;
            end else begin
              counter_d = counter_q + 8'd1;
            end
          end else begin
            tim_acc_d = tim_sat;
          end
        end
        if (div_sum >= DivSumW'(DIV_PERIOD)) begin
          div_acc_d = '0;
          div_cnt_d = div_cnt_q + 8'd1;
        end else begin
          div_acc_d = div_sum[DivAccW-1:0];
        end
      end
      tiad_pkg::CmdWrite: begin
        case (tiad_pkg::sel_e'(item_i.reg_select))
          tiad_pkg::SelDivider: begin
            div_cnt_d = '0;
            div_acc_d = '0;
          end
          tiad_pkg::SelCounter: counter_d = item_i.write_data;
          tiad_pkg::SelModulo:  modulo_d  = item_i.write_data;
          tiad_pkg::SelControl: control_d = item_i.write_data;
          tiad_pkg::SelRequest: request_d = item_i.write_data;
          tiad_pkg::SelEnable:  enable_d  = item_i.write_data;
          default: ;
        endcase
      end
      tiad_pkg::CmdRead: begin
        case (tiad_pkg::sel_e'(item_i.reg_select))
          tiad_pkg::SelDivider: res.read_data = div_cnt_q;
          tiad_pkg::SelCounter: res.read_data = counter_q;
          tiad_pkg::SelModulo:  res.read_data = modulo_q;
          tiad_pkg::SelControl: res.read_data = control_q;
          tiad_pkg::SelRequest: res.read_data = request_q;
          tiad_pkg::SelEnable:  res.read_data = enable_q;
          default:              res.read_data = '0;
        endcase
      end
      tiad_pkg::CmdDispatch: begin
        if (master_q && pend_found) begin
          request_d[pend_line] = 1'b0;
          master_d             = 1'b0;
          res.irq_taken        = 1'b1;
          res.irq_line         = pend_line;
          res.irq_vector       = tiad_pkg::VecBase + {1'b0, pend_line, 3'b000};
        end
      end
      tiad_pkg::CmdSetMaster: master_d = item_i.write_data[0];
      default: ;
    endcase
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= tiad_pkg::PeriodReset;
      div_cnt_q <= '0;
      div_acc_q <= '0;
      tim_acc_q <= '0;
      counter_q <= '0;
      modulo_q  <= '0;
      control_q <= '0;
      request_q <= '0;
      enable_q  <= '0;
      master_q  <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_data_i;
      end
      if (exec_i) begin
        div_cnt_q <= div_cnt_d;
        div_acc_q <= div_acc_d;
        tim_acc_q <= tim_acc_d;
        counter_q <= counter_d;
        modulo_q  <= modulo_d;
        control_q <= control_d;
        request_q <= request_d;
        enable_q  <= enable_d;
        master_q  <= master_d;
      end
    end
  end

`include "timer_and_interrupt_dispatch_assert.svh"

  `TIAD_ASSERT_NXT(a_dispatch_clears_master, exec_i && res.irq_taken, !master_q, "master left set")
  `TIAD_ASSERT_NXT(a_overflow_sets_req, exec_i && res.timer_overflow, request_q[tiad_pkg::TimerLine], "timer request missing")
  `TIAD_ASSERT_IMP(a_taken_needs_master, res.irq_taken, master_q && pend_found, "dispatch without pending line")
  `TIAD_ASSERT_NXT(a_divider_wraps, exec_i && div_cnt_d != div_cnt_q && item_i.command == tiad_pkg::CmdTick, div_acc_q == '0, "divider accumulator not cleared")

endmodule
